// ===== rtl/core/qrv_pkg.sv =====
// ---------------------------------------------------------------------------
// qrv_pkg
// Types and constants shared by the quaternion vector rotation core.
// ---------------------------------------------------------------------------
package qrv_pkg;

  localparam int VEC_WIDTH      = 16;
  localparam int QUAT_WIDTH     = 16;
  localparam int QUAT_FRAC_BITS = 15;
  localparam int SHIFT          = 2 * QUAT_FRAC_BITS;

  localparam int PROD1_W = VEC_WIDTH + QUAT_WIDTH;
  localparam int P_W     = PROD1_W + 2;
  localparam int PROD2_W = P_W + QUAT_WIDTH;
  localparam int R_W     = PROD2_W + 2;
  localparam int T_W     = R_W - SHIFT;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = QUAT_WIDTH;

  localparam logic [CFG_INDEX_W-1:0] REG_ROT_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_Z = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_W = 2'd3;

  localparam logic signed [QUAT_WIDTH-1:0] ROT_W_RESET = {1'b0, {(QUAT_WIDTH-1){1'b1}}};

  localparam logic signed [R_W-1:0] ROUND_HALF =
    {{(R_W-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};

  localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] vec_x;
    logic signed [VEC_WIDTH-1:0] vec_y;
    logic signed [VEC_WIDTH-1:0] vec_z;
  } vec_word_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        clipped;
  } res_word_t;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
    logic signed [QUAT_WIDTH-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
    logic signed [P_W-1:0] w;
  } pquat_t;

  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

endpackage

// ===== rtl/core/qrv_left_prod.sv =====
// ---------------------------------------------------------------------------
// qrv_left_prod
// Two pipeline stages forming p = q * (v, 0): products, then sums.
// ---------------------------------------------------------------------------
module qrv_left_prod import qrv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  vec_word_t vec,
  input  quat_t     rot,
  output logic      out_valid,
  input  logic      out_stall,
  output pquat_t    p
);

  logic s1_valid;
  logic s2_valid;
  logic ready1;
  logic ready2;

  logic signed [PROD1_W-1:0] wx, yz, zy, wy, zx, xz, wz, xy, yx, xx, yy, zz;
  pquat_t p_reg;

  assign ready2   = !s2_valid || !out_stall;
  assign ready1   = !s1_valid || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ready1) s1_valid <= in_valid;
      if (ready2) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      wx <= rot.w * vec.vec_x;
      yz <= rot.y * vec.vec_z;
      zy <= rot.z * vec.vec_y;
      wy <= rot.w * vec.vec_y;
      zx <= rot.z * vec.vec_x;
      xz <= rot.x * vec.vec_z;
      wz <= rot.w * vec.vec_z;
      xy <= rot.x * vec.vec_y;
      yx <= rot.y * vec.vec_x;
      xx <= rot.x * vec.vec_x;
      yy <= rot.y * vec.vec_y;
      zz <= rot.z * vec.vec_z;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      p_reg.x <= P_W'(wx) + P_W'(yz) - P_W'(zy);
      p_reg.y <= P_W'(wy) + P_W'(zx) - P_W'(xz);
      p_reg.z <= P_W'(wz) + P_W'(xy) - P_W'(yx);
      p_reg.w <= -P_W'(xx) - P_W'(yy) - P_W'(zz);
    end
  end

  assign out_valid = s2_valid;
  assign p         = p_reg;

endmodule

// ===== rtl/core/qrv_right_prod.sv =====
// ---------------------------------------------------------------------------
// qrv_right_prod
// Two pipeline stages forming the vector part of p * conj(q), plus half LSB.
// ---------------------------------------------------------------------------
module qrv_right_prod import qrv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  pquat_t p,
  input  quat_t  rot,
  output logic   out_valid,
  input  logic   out_stall,
  output rvec_t  r
);

  logic s3_valid;
  logic s4_valid;
  logic ready3;
  logic ready4;

  logic signed [PROD2_W-1:0] ax0, ax1, ax2, ax3;
  logic signed [PROD2_W-1:0] ay0, ay1, ay2, ay3;
  logic signed [PROD2_W-1:0] az0, az1, az2, az3;
  rvec_t r_reg;

  assign ready4   = !s4_valid || !out_stall;
  assign ready3   = !s3_valid || ready4;
  assign in_stall = !ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (ready3) s3_valid <= in_valid;
      if (ready4) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_valid) begin
      ax0 <= p.w * rot.x;
      ax1 <= p.x * rot.w;
      ax2 <= p.y * rot.z;
      ax3 <= p.z * rot.y;
      ay0 <= p.w * rot.y;
      ay1 <= p.y * rot.w;
      ay2 <= p.z * rot.x;
      ay3 <= p.x * rot.z;
      az0 <= p.w * rot.z;
      az1 <= p.z * rot.w;
      az2 <= p.x * rot.y;
      az3 <= p.y * rot.x;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && s3_valid) begin
      r_reg.x <= ROUND_HALF - R_W'(ax0) + R_W'(ax1) - R_W'(ax2) + R_W'(ax3);
      r_reg.y <= ROUND_HALF - R_W'(ay0) + R_W'(ay1) - R_W'(ay2) + R_W'(ay3);
      r_reg.z <= ROUND_HALF - R_W'(az0) + R_W'(az1) - R_W'(az2) + R_W'(az3);
    end
  end

  assign out_valid = s4_valid;
  assign r         = r_reg;

endmodule

// ===== rtl/core/qrv_round_sat.sv =====
// ---------------------------------------------------------------------------
// qrv_round_sat
// Output stage: drop fraction bits, saturate, flag clipping.
// ---------------------------------------------------------------------------
module qrv_round_sat import qrv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  rvec_t     r,
  output logic      out_valid,
  input  logic      out_stall,
  output res_word_t res
);

  logic      s5_valid;
  logic      ready5;
  res_word_t res_reg;
  res_word_t res_next;

  logic signed [T_W-1:0] tx, ty, tz;
  logic ok_x, ok_y, ok_z;

  assign ready5   = !s5_valid || !out_stall;
  assign in_stall = !ready5;

  assign tx = r.x[R_W-1:SHIFT];
  assign ty = r.y[R_W-1:SHIFT];
  assign tz = r.z[R_W-1:SHIFT];

  assign ok_x = (&tx[T_W-1:VEC_WIDTH-1]) || !(|tx[T_W-1:VEC_WIDTH-1]);
  assign ok_y = (&ty[T_W-1:VEC_WIDTH-1]) || !(|ty[T_W-1:VEC_WIDTH-1]);
  assign ok_z = (&tz[T_W-1:VEC_WIDTH-1]) || !(|tz[T_W-1:VEC_WIDTH-1]);

  always_comb begin
    res_next.out_x   = ok_x ? tx[VEC_WIDTH-1:0] : (tx[T_W-1] ? VEC_MIN : VEC_MAX);
    res_next.out_y   = ok_y ? ty[VEC_WIDTH-1:0] : (ty[T_W-1] ? VEC_MIN : VEC_MAX);
    res_next.out_z   = ok_z ? tz[VEC_WIDTH-1:0] : (tz[T_W-1] ? VEC_MIN : VEC_MAX);
    res_next.clipped = !(ok_x && ok_y && ok_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (ready5) begin
      s5_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && in_valid) res_reg <= res_next;
  end

  assign out_valid = s5_valid;
  assign res       = res_reg;

endmodule

// ===== rtl/core/quaternion_rotate_vector_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_rotate_vector_core
// Rotates each incoming 3-vector by the quaternion held in rot_x..rot_w.
//
// Input channel vec_valid / vec_stall / vec carries one vector per word;
// output channel res_valid / res_stall / res carries the rotated, rounded
// and saturated vector with the clipped flag. A word moves when valid is
// high and stall is low. Registers are written through cfg_we, cfg_index
// (0 rot_x, 1 rot_y, 2 rot_z, 3 rot_w) and cfg_data; the user must write
// them only while idle; the block itself does not enforce this. Throughput
// is one word per cycle while the receiver does not stall, with five
// register stages (two multiply and two add stages for the two Hamilton
// products, one rounding stage). Reset empties the pipeline and loads the
// identity-like quaternion (0, 0, 0, 32767). When the receiver stalls,
// each stage holds its word and fills any empty stage ahead of it; the
// input stalls only once all five stages are full.
// ---------------------------------------------------------------------------
module quaternion_rotate_vector_core import qrv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   vec_valid,
  output logic                   vec_stall,
  input  vec_word_t              vec,
  output logic                   res_valid,
  input  logic                   res_stall,
  output res_word_t              res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  quat_t  rot;
  pquat_t p;
  rvec_t  r;
  logic   lp_valid;
  logic   lp_stall;
  logic   rp_valid;
  logic   rp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot.x <= '0;
      rot.y <= '0;
      rot.z <= '0;
      rot.w <= ROT_W_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT_X: rot.x <= cfg_data;
        REG_ROT_Y: rot.y <= cfg_data;
        REG_ROT_Z: rot.z <= cfg_data;
        REG_ROT_W: rot.w <= cfg_data;
        default: rot <= rot;
      endcase
    end
  end

  qrv_left_prod u_left (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec_valid),
    .in_stall  (vec_stall),
    .vec       (vec),
    .rot       (rot),
    .out_valid (lp_valid),
    .out_stall (lp_stall),
    .p         (p)
  );

  qrv_right_prod u_right (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lp_valid),
    .in_stall  (lp_stall),
    .p         (p),
    .rot       (rot),
    .out_valid (rp_valid),
    .out_stall (rp_stall),
    .r         (r)
  );

  qrv_round_sat u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rp_valid),
    .in_stall  (rp_stall),
    .r         (r),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .res       (res)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> (res_valid && res_stall))
    else $error("input stalled while output side could advance");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.clipped) |->
      (res.out_x == VEC_MAX || res.out_x == VEC_MIN ||
       res.out_y == VEC_MAX || res.out_y == VEC_MIN ||
       res.out_z == VEC_MAX || res.out_z == VEC_MIN))
    else $error("clipped flag set with no component at a limit");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_rotate_vector_core. A short table of
// directed vectors (reset quaternion, axis half-turns, zero and non-unit
// quaternions, rounding ties) is followed by random phases, each under a
// fresh quaternion. Each word is predicted by its listed result, else by
// exact integer rotation q * (v, 0) * conj(q), rounded and saturated, and
// compared field by field with the output. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb;
  import qrv_pkg::*;

  typedef struct {
    quat_t     q;
    vec_word_t v;
    bit        known;
    res_word_t r;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   vec_valid = 1'b0;
  logic                   vec_stall;
  vec_word_t              vec = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  res_word_t              res;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ROT_X;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  quat_t     rot_model;
  res_word_t pending_res[$];
  dir_row_t  dir_rows[$];
  quat_t     row_q;
  bit        quiet = 1'b0;
  int        fault_count = 0;

  quaternion_rotate_vector_core DUT (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [VEC_WIDTH-1:0] narrow(input longint acc, output bit hit);
    longint t;
    t = (acc + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
    hit = 1'b0;
    if (t > longint'(VEC_MAX)) begin
      t = longint'(VEC_MAX);
      hit = 1'b1;
    end else if (t < longint'(VEC_MIN)) begin
      t = longint'(VEC_MIN);
      hit = 1'b1;
    end
    return t[VEC_WIDTH-1:0];
  endfunction

  function automatic res_word_t rotate_vec(input quat_t q, input vec_word_t v);
    longint x, y, z, w, vx, vy, vz;
    longint px, py, pz, pw, rx, ry, rz;
    bit cx, cy, cz;
    res_word_t r;
    x = $signed(q.x);
    y = $signed(q.y);
    z = $signed(q.z);
    w = $signed(q.w);
    vx = $signed(v.vec_x);
    vy = $signed(v.vec_y);
    vz = $signed(v.vec_z);
    px = w * vx + y * vz - z * vy;
    py = w * vy + z * vx - x * vz;
    pz = w * vz + x * vy - y * vx;
    pw = -(x * vx) - y * vy - z * vz;
    rx = -(pw * x) + px * w - py * z + pz * y;
    ry = -(pw * y) + py * w - pz * x + px * z;
    rz = -(pw * z) + pz * w - px * y + py * x;
    r.out_x = narrow(rx, cx);
    r.out_y = narrow(ry, cy);
    r.out_z = narrow(rz, cz);
    r.clipped = cx | cy | cz;
    return r;
  endfunction

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      4: return 16'h0001;
      default: return 16'hc000;
    endcase
  endfunction

  function automatic vec_word_t rand_vec();
    vec_word_t v;
    int sel;
    sel = int'($urandom_range(99));
    if (sel < 70) begin
      v.vec_x = VEC_WIDTH'($urandom);
      v.vec_y = VEC_WIDTH'($urandom);
      v.vec_z = VEC_WIDTH'($urandom);
    end else if (sel < 85) begin
      v.vec_x = VEC_WIDTH'(int'($urandom_range(510)) - 255);
      v.vec_y = VEC_WIDTH'(int'($urandom_range(510)) - 255);
      v.vec_z = VEC_WIDTH'(int'($urandom_range(510)) - 255);
    end else begin
      v.vec_x = pick_edge();
      v.vec_y = pick_edge();
      v.vec_z = pick_edge();
    end
    return v;
  endfunction

  function automatic quat_t rand_quat();
    logic [QUAT_WIDTH-1:0] c[4];
    int kind;
    quat_t q;
    kind = int'($urandom_range(3));
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: c[i] = QUAT_WIDTH'($urandom);
        1: c[i] = QUAT_WIDTH'(int'($urandom_range(32766)) - 16383);
        2: c[i] = QUAT_WIDTH'(int'($urandom_range(510)) - 255);
        default: c[i] = pick_edge();
      endcase
    end
    if (kind == 2) c[$urandom_range(3)] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
    q.x = c[0];
    q.y = c[1];
    q.z = c[2];
    q.w = c[3];
    return q;
  endfunction

  task automatic load_quat(input quat_t q);
    vec_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROT_X;
    cfg_data <= q.x;
    @(posedge clk);
    cfg_index <= REG_ROT_Y;
    cfg_data <= q.y;
    @(posedge clk);
    cfg_index <= REG_ROT_Z;
    cfg_data <= q.z;
    @(posedge clk);
    cfg_index <= REG_ROT_W;
    cfg_data <= q.w;
    @(posedge clk);
    cfg_we <= 1'b0;
    rot_model = q;
  endtask

  task automatic send_vec(input vec_word_t v, input res_word_t want);
    while (!quiet && $urandom_range(99) < 16) begin
      vec_valid <= 1'b0;
      @(posedge clk);
    end
    vec_valid <= 1'b1;
    vec <= v;
    @(posedge clk);
    while (vec_stall) @(posedge clk);
    pending_res.push_back(want);
  endtask

  task automatic dir_quat(input int x, input int y, input int z, input int w);
    row_q.x = QUAT_WIDTH'(x);
    row_q.y = QUAT_WIDTH'(y);
    row_q.z = QUAT_WIDTH'(z);
    row_q.w = QUAT_WIDTH'(w);
  endtask

  task automatic dir_row(input int vx, input int vy, input int vz, input bit known,
                         input int ox, input int oy, input int oz, input bit oc);
    dir_row_t row;
    row.q = row_q;
    row.v.vec_x = VEC_WIDTH'(vx);
    row.v.vec_y = VEC_WIDTH'(vy);
    row.v.vec_z = VEC_WIDTH'(vz);
    row.known = known;
    row.r.out_x = VEC_WIDTH'(ox);
    row.r.out_y = VEC_WIDTH'(oy);
    row.r.out_z = VEC_WIDTH'(oz);
    row.r.clipped = oc;
    dir_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(99) < 16);
  end

  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_res.size() == 0) begin
        $error("unexpected word out_x=%0d out_y=%0d out_z=%0d clipped=%0b",
               res.out_x, res.out_y, res.out_z, res.clipped);
        fault_count++;
      end else begin
        want = pending_res.pop_front();
        if (res.out_x !== want.out_x) begin
          $error("out_x expected %0d actual %0d", want.out_x, res.out_x);
          fault_count++;
        end
        if (res.out_y !== want.out_y) begin
          $error("out_y expected %0d actual %0d", want.out_y, res.out_y);
          fault_count++;
        end
        if (res.out_z !== want.out_z) begin
          $error("out_z expected %0d actual %0d", want.out_z, res.out_z);
          fault_count++;
        end
        if (res.clipped !== want.clipped) begin
          $error("clipped expected %0b actual %0b", want.clipped, res.clipped);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    res_word_t want;
    rot_model.x = '0;
    rot_model.y = '0;
    rot_model.z = '0;
    rot_model.w = ROT_W_RESET;

    dir_quat(0, 0, 0, 32767);
    dir_row(0, 0, 0, 1, 0, 0, 0, 0);
    dir_row(32767, -32768, -1, 0, 0, 0, 0, 0);
    dir_row(-32768, 32767, 1, 0, 0, 0, 0, 0);
    dir_quat(0, 0, 0, -32768);
    dir_row(32767, -32768, 1, 1, 32767, -32768, 1, 0);
    dir_row(-1, 0, 12345, 1, -1, 0, 12345, 0);
    dir_quat(-32768, 0, 0, 0);
    dir_row(-32768, -32768, 5, 1, -32768, 32767, -5, 1);
    dir_quat(0, -32768, 0, 0);
    dir_row(100, -200, 300, 1, -100, -200, -300, 0);
    dir_quat(0, 0, -32768, 0);
    dir_row(-32768, 7, -9, 1, 32767, -7, -9, 1);
    dir_quat(0, 0, 0, 0);
    dir_row(32767, -32768, -32768, 1, 0, 0, 0, 0);
    dir_row(-1, 1, -1, 1, 0, 0, 0, 0);
    dir_quat(0, 0, 0, 16384);
    dir_row(2, -2, 6, 1, 1, 0, 2, 0);
    dir_row(-6, 1, -1, 1, -1, 0, 0, 0);
    dir_row(32767, -32768, 3, 0, 0, 0, 0, 0);
    dir_quat(-32768, -32768, -32768, -32768);
    dir_row(32767, 32767, 32767, 0, 0, 0, 0, 0);
    dir_row(-32768, 12345, -1, 0, 0, 0, 0, 0);
    dir_quat(32767, 32767, 32767, 32767);
    dir_row(32767, -32768, 0, 0, 0, 0, 0, 0);
    dir_quat(16384, 16384, 16384, 16384);
    dir_row(1000, -2000, 3000, 0, 0, 0, 0, 0);
    dir_quat(23170, 0, 0, 23170);
    dir_row(32767, 32767, -32768, 0, 0, 0, 0, 0);
    dir_quat(-32768, 32767, -32768, 32767);
    dir_row(-32768, -32768, -32768, 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].q !== rot_model) load_quat(dir_rows[i].q);
      want = dir_rows[i].known ? dir_rows[i].r : rotate_vec(rot_model, dir_rows[i].v);
      send_vec(dir_rows[i].v, want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      vec_word_t v;
      quiet = (ph == 4);
      load_quat(rand_quat());
      for (int n = 0; n < 160; n++) begin
        v = rand_vec();
        send_vec(v, rotate_vec(rot_model, v));
      end
    end
    quiet = 1'b0;

    vec_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/qrv_pkg.sv
rtl/core/qrv_left_prod.sv
rtl/core/qrv_right_prod.sv
rtl/core/qrv_round_sat.sv
rtl/core/quaternion_rotate_vector_core.sv
tb/tb.sv
